// ----- hw/rtl/mrw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrw_pkg: shared types for the Miller-Rabin witness test
// Word types of the input and result channels and the cause codes.
// ----------------------------------------------------------------------------
package mrw_pkg;

  localparam int FIELD_W = 32;

  typedef logic [1:0] cause_t;

  localparam cause_t CAUSE_NONE   = 2'd0;  // probably prime for this base
  localparam cause_t CAUSE_SQRT   = 2'd1;  // nontrivial square root of one
  localparam cause_t CAUSE_FERMAT = 2'd2;  // last value not one

  typedef struct packed {
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] modulus;
  } in_word_t;

  typedef struct packed {
    logic   composite;
    cause_t cause;
  } out_word_t;

endpackage

// ----- hw/rtl/mrw_modmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrw_modmul: iterative modular multiplier
// Forms x*y mod n one bit of y per cycle, top bit first, by doubling the
// partial result, adding x when the bit is set and reducing by 0, n or 2n.
// Needs x < n and n >= 2. Result is valid while done is high.
// ----------------------------------------------------------------------------
module mrw_modmul #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] n,
  output logic             busy,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] r;
  logic [WIDTH-1:0] xr;
  logic [WIDTH-1:0] yr;
  logic [WIDTH-1:0] nr;
  logic [CW-1:0]    cnt;

  logic [WIDTH+1:0] p;
  logic [WIDTH+1:0] c1;
  logic [WIDTH+1:0] c2;
  logic [WIDTH-1:0] r_next;

  // 2r + b*x < 3n, so one of p, p-n, p-2n lands in [0, n)
  always_comb begin
    p  = {1'b0, r, 1'b0} + (yr[WIDTH-1] ? {2'b00, xr} : '0);
    c1 = p - {2'b00, nr};
    c2 = p - {1'b0, nr, 1'b0};
    if (!c2[WIDTH+1]) begin
      r_next = c2[WIDTH-1:0];
    end else if (!c1[WIDTH+1]) begin
      r_next = c1[WIDTH-1:0];
    end else begin
      r_next = p[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // one-cycle pulse after the last bit
      done <= busy && (cnt == '0);
      if (start && !busy) begin
        busy <= 1'b1;
        r    <= '0;
        xr   <= x;
        yr   <= y;
        nr   <= n;
        cnt  <= CW'(WIDTH - 1);
      end else if (busy) begin
        r  <= r_next;
        yr <= {yr[WIDTH-2:0], 1'b0};
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign result = r;

  a_start_idle : assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("modmul: start while busy");

  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("modmul: done without a run");

  a_result_reduced : assert property (@(posedge clk) disable iff (rst)
    done |-> (r < nr))
    else $error("modmul: result not reduced");

endmodule

// ----- hw/rtl/miller_rabin_witness_test_top.sv -----
`timescale 1ns / 1ps
// Work: a word needs at most 1 + WIDTH + (set bits of u) + t products, t being the
//   trailing zeros of n-1; this is never above 1 + 2*WIDTH products.
// Throughput: one word at a time; in_stall stays high from acceptance until
//   the result is in the output register, paced by the shared multiplier.
// Reset: synchronous, active high; sequencer to idle, output register empty.
// ----------------------------------------------------------------------------
// miller_rabin_witness_test_top: one-base Miller-Rabin witness test
// Splits n-1 into u*2^t, reduces the base mod n, raises it to u by
// square-and-multiply and then squares t times, flagging a nontrivial
// square root of one or a failed Fermat check.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test_top #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mrw_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mrw_pkg::out_word_t out_data
);

  import mrw_pkg::*;

  localparam int CW = $clog2(WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,    // waiting for a word
    ST_SPLIT,   // strip trailing zeros of n-1, one per cycle
    ST_REDUCE,  // base mod n as 1*base mod n
    ST_POW_SQ,  // d = d*d
    ST_POW_MUL, // d = d*a
    ST_SQ,      // x = x*x, t times
    ST_FIN      // hand the verdict to the output register
  } state_t;

  state_t           state;

  logic [WIDTH-1:0] a;       // base, later base mod n
  logic [WIDTH-1:0] n;
  logic [WIDTH-1:0] nm1;     // n-1, for the square root test
  logic [WIDTH-1:0] e;       // odd part u, shifted left as bits are used
  logic [CW-1:0]    t;       // squarings still to do
  logic [CW-1:0]    bitcnt;  // exponent bits still to do
  logic [WIDTH-1:0] d;       // running value
  logic             fin_comp;
  cause_t           fin_cause;

  // multiplier hand-off
  logic             mul_start;
  logic [WIDTH-1:0] mul_x;
  logic [WIDTH-1:0] mul_y;
  logic             mul_busy;
  logic             mul_done;
  logic [WIDTH-1:0] mul_res;

  // output register
  logic             res_valid;
  out_word_t        res;

  logic             in_take;
  logic             out_take;
  logic             out_free;
  logic [WIDTH-1:0] base_w;
  logic [WIDTH-1:0] mod_w;

  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = res_valid && !out_stall;
  assign out_free  = !res_valid || !out_stall;
  assign out_valid = res_valid;
  assign out_data  = res;

  // inputs are taken modulo 2^WIDTH
  assign base_w = WIDTH'(in_data.base);
  assign mod_w  = WIDTH'(in_data.modulus);

  mrw_modmul #(
    .WIDTH (WIDTH)
  ) u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .x      (mul_x),
    .y      (mul_y),
    .n      (n),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (mul_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mul_start <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // output register: filled from ST_FIN, emptied when taken
      if (state == ST_FIN && out_free) begin
        res_valid <= 1'b1;
      end else if (out_take) begin
        res_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          mul_start <= 1'b0;
          if (in_take) begin
            a   <= base_w;
            n   <= mod_w;
            nm1 <= mod_w - 1'b1;
            e   <= mod_w - 1'b1;
            t   <= '0;
            if (mod_w < WIDTH'(2)) begin
              // 0 and 1 are not prime
              fin_comp  <= 1'b1;
              fin_cause <= CAUSE_FERMAT;
              state     <= ST_FIN;
            end else begin
              state <= ST_SPLIT;
            end
          end
        end

        ST_SPLIT: begin
          if (!e[0]) begin
            mul_start <= 1'b0;
            e         <= {1'b0, e[WIDTH-1:1]};
            t         <= t + 1'b1;
          end else begin
            mul_start <= 1'b1;
            mul_x     <= WIDTH'(1);
            mul_y     <= a;
            state     <= ST_REDUCE;
          end
        end

        ST_REDUCE: begin
          mul_start <= mul_done;
          if (mul_done) begin
            a         <= mul_res;
            d         <= WIDTH'(1);
            bitcnt    <= CW'(WIDTH - 1);
            mul_x     <= WIDTH'(1);
            mul_y     <= WIDTH'(1);
            state     <= ST_POW_SQ;
          end
        end

        ST_POW_SQ, ST_POW_MUL: begin
          if (mul_done) begin
            d <= mul_res;
            if (state == ST_POW_SQ && e[WIDTH-1]) begin
              mul_start <= 1'b1;
              mul_x     <= mul_res;
              mul_y     <= a;
              state     <= ST_POW_MUL;
            end else if (bitcnt != '0) begin
              bitcnt    <= bitcnt - 1'b1;
              e         <= {e[WIDTH-2:0], 1'b0};
              mul_start <= 1'b1;
              mul_x     <= mul_res;
              mul_y     <= mul_res;
              state     <= ST_POW_SQ;
            end else if (t != '0) begin
              mul_start <= 1'b1;
              mul_x     <= mul_res;
              mul_y     <= mul_res;
              state     <= ST_SQ;
            end else begin
              mul_start <= 1'b0;
              fin_comp  <= (mul_res != WIDTH'(1));
              fin_cause <= (mul_res != WIDTH'(1)) ? CAUSE_FERMAT : CAUSE_NONE;
              state     <= ST_FIN;
            end
          end else begin
            mul_start <= 1'b0;
          end
        end

        ST_SQ: begin
          if (mul_done) begin
            d <= mul_res;
            t <= t - 1'b1;
            if (mul_res == WIDTH'(1) && d != WIDTH'(1) && d != nm1) begin
              mul_start <= 1'b0;
              fin_comp  <= 1'b1;
              fin_cause <= CAUSE_SQRT;
              state     <= ST_FIN;
            end else if (t != CW'(1)) begin
              mul_start <= 1'b1;
              mul_x     <= mul_res;
              mul_y     <= mul_res;
            end else begin
              mul_start <= 1'b0;
              fin_comp  <= (mul_res != WIDTH'(1));
              fin_cause <= (mul_res != WIDTH'(1)) ? CAUSE_FERMAT : CAUSE_NONE;
              state     <= ST_FIN;
            end
          end else begin
            mul_start <= 1'b0;
          end
        end

        ST_FIN: begin
          mul_start <= 1'b0;
          if (out_free) begin
            res.composite <= fin_comp;
            res.cause     <= fin_cause;
            state         <= ST_IDLE;
          end
        end

        default: begin
          mul_start <= 1'b0;
          state     <= ST_IDLE;
        end
      endcase
    end
  end

  a_verdict_consistent : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.composite == (res.cause != CAUSE_NONE)))
    else $error("top: verdict and cause disagree");

  a_done_expected : assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_REDUCE || state == ST_POW_SQ ||
                  state == ST_POW_MUL || state == ST_SQ))
    else $error("top: product arrived outside a wait state");

  a_start_when_free : assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy)
    else $error("top: product issued to a busy multiplier");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_stall) |=> ($stable(res) && res_valid))
    else $error("top: stalled result overwritten");

endmodule
